[src/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// lrt_pkg
// shared types, constants and arithmetic helpers of the trainer
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int FEATURES = 9;
    localparam int IDX_W    = $clog2(FEATURES + 1);
    localparam int ADR_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;

    localparam logic [1:0] OP_TRAIN   = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_PREDICT = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [2:0] REG_LR    = 3'd0;
    localparam logic [2:0] REG_C0    = 3'd1;
    localparam logic [2:0] REG_C1    = 3'd2;
    localparam logic [2:0] REG_C3    = 3'd3;
    localparam logic [2:0] REG_THR   = 3'd4;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] feature;
        logic               label;
        logic               last_feature;
    } t_req;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > 66'sd140737488355327) return MAX48;
        if (v < -66'sd140737488355328) return MIN48;
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -66'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

[src/lrt_stream_if.sv]
// ----------------------------------------------------------------------------
// lrt_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface lrt_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/lrt_ram.sv]
// ----------------------------------------------------------------------------
// lrt_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module lrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/lrt_front.sv]
// ----------------------------------------------------------------------------
// lrt_front
// accepts requests into a short queue for the back end
// ----------------------------------------------------------------------------
module lrt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrt_stream_if.sink    s_in,
    output logic          o_q_valid,
    output lrt_pkg::t_req o_q_req,
    input  logic          i_q_pop
);
    lrt_pkg::t_req r_q [lrt_pkg::QDEPTH];
    logic [lrt_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [lrt_pkg::QPTR_W:0]   r_cnt;
    logic push;
    lrt_pkg::t_req in_req;

    assign in_req.op           = s_in.data[19:18];
    assign in_req.feature      = s_in.data[17:2];
    assign in_req.label        = s_in.data[1];
    assign in_req.last_feature = s_in.data[0];

    assign s_in.ready = (r_cnt != (lrt_pkg::QPTR_W + 1)'(lrt_pkg::QDEPTH));
    assign push       = s_in.valid && s_in.ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_req    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= in_req;
                r_wp      <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (lrt_pkg::QPTR_W + 1)'(push) - (lrt_pkg::QPTR_W + 1)'(i_q_pop);
        end
    end
endmodule

[src/lrt_back.sv]
// ----------------------------------------------------------------------------
// lrt_back
// sequencer that executes train, update, predict and clear requests
// ----------------------------------------------------------------------------
module lrt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lrt_pkg::t_req      i_q_req,
    output logic               o_q_pop,
    input  logic [15:0]        i_lr,
    input  logic signed [31:0] i_c0,
    input  logic signed [31:0] i_c1,
    input  logic signed [31:0] i_c3,
    input  logic signed [31:0] i_thr,
    lrt_stream_if.source       m_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_UPD_MUL, S_UPD_WR, S_SQ, S_CUBE, S_POLY, S_SUM,
        S_GRD_RD, S_GRD_MUL, S_GRD_WR
    } t_state;

    localparam int AW = lrt_pkg::ADR_W;
    localparam int IW = lrt_pkg::IDX_W;

    t_state r_state;
    logic signed [31:0] r_w [lrt_pkg::FEATURES];
    logic signed [47:0] r_g [lrt_pkg::FEATURES];
    logic [IW-1:0]      r_idx, r_cnt, r_j;
    logic signed [47:0] r_dot;
    logic signed [65:0] r_prod, r_prod2;
    logic signed [31:0] r_s, r_s2, r_sig;
    logic signed [31:0] r_err;
    logic               r_label;
    logic               r_ovalid;
    logic               r_opred;
    logic signed [31:0] r_oscore;
    logic               r_pop;

    logic               buf_we;
    logic [AW-1:0]      buf_waddr, buf_raddr;
    logic [15:0]        buf_rdata;

    assign buf_we    = (r_state == S_ACC) && (r_idx < IW'(lrt_pkg::FEATURES));
    assign buf_waddr = r_idx[AW-1:0];
    assign buf_raddr = r_j[AW-1:0];
    assign o_q_pop   = r_pop;

    lrt_ram #(.WIDTH(16), .DEPTH(lrt_pkg::FEATURES), .AW(AW)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_q_req.feature),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    assign m_out.valid = r_ovalid;
    assign m_out.data  = {r_opred, r_oscore};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_dot    <= '0;
            r_ovalid <= 1'b0;
            r_pop    <= 1'b0;
            r_j      <= '0;
            for (int k = 0; k < lrt_pkg::FEATURES; k++) begin
                r_w[k] <= '0;
                r_g[k] <= '0;
            end
        end else begin
            r_pop <= 1'b0;
            if (m_out.valid && m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !r_pop) begin
                        unique case (i_q_req.op)
                            lrt_pkg::OP_UPDATE: begin
                                r_j     <= '0;
                                r_state <= S_UPD_MUL;
                            end
                            lrt_pkg::OP_CLEAR: begin
                                for (int k = 0; k < lrt_pkg::FEATURES; k++) begin
                                    r_w[k] <= '0;
                                end
                                r_pop <= 1'b1;
                            end
                            default: begin
                                r_state <= S_ACC;
                            end
                        endcase
                    end
                end
                S_ACC: begin
                    // a predict close waits for a free output register
                    if (!(i_q_req.last_feature && i_q_req.op == lrt_pkg::OP_PREDICT
                          && r_ovalid && !m_out.ready)) begin
                        logic signed [47:0] dn;
                        dn = r_dot;
                        if (r_idx < IW'(lrt_pkg::FEATURES)) begin
                            dn = lrt_pkg::sat48(66'(r_dot) + 66'(
                                (66'(r_w[r_idx[AW-1:0]]) * 66'(i_q_req.feature)) >>> 12));
                        end
                        r_pop   <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_idx < IW'(lrt_pkg::FEATURES)) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_dot <= dn;
                        if (i_q_req.last_feature) begin
                            r_cnt   <= (r_idx < IW'(lrt_pkg::FEATURES)) ?
                                       r_idx + 1'b1 : r_idx;
                            r_idx   <= '0;
                            r_dot   <= '0;
                            r_label <= i_q_req.label;
                            if (i_q_req.op == lrt_pkg::OP_PREDICT) begin
                                logic signed [31:0] sc;
                                sc = lrt_pkg::sat32(66'(dn));
                                r_ovalid <= 1'b1;
                                r_oscore <= sc;
                                r_opred  <= (sc >= i_thr);
                            end else begin
                                r_s     <= lrt_pkg::sat32(66'(dn));
                                r_state <= S_SQ;
                            end
                        end
                    end
                end
                S_UPD_MUL: begin
                    r_prod  <= 66'(signed'({1'b0, i_lr})) * 66'(r_g[r_j[AW-1:0]]);
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    r_w[r_j[AW-1:0]] <= lrt_pkg::sat32(66'(r_w[r_j[AW-1:0]])
                                                       - (r_prod >>> 16));
                    r_g[r_j[AW-1:0]] <= '0;
                    if (r_j == IW'(lrt_pkg::FEATURES - 1)) begin
                        r_pop   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_UPD_MUL;
                    end
                end
                S_SQ: begin
                    r_s2    <= lrt_pkg::sat32((66'(r_s) * 66'(r_s)) >>> 16);
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    r_prod  <= 66'(r_s2) * 66'(r_s);
                    r_state <= S_POLY;
                end
                S_POLY: begin
                    r_prod  <= 66'(i_c3) * 66'(lrt_pkg::sat32(r_prod >>> 16));
                    r_prod2 <= 66'(i_c1) * 66'(r_s);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sig   <= lrt_pkg::sat32(66'(i_c0) + (r_prod2 >>> 16)
                                              + (r_prod >>> 16));
                    r_j     <= '0;
                    r_state <= S_GRD_RD;
                end
                S_GRD_RD: begin
                    r_err <= r_sig;
                    if (r_j >= r_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_GRD_MUL;
                    end
                end
                S_GRD_MUL: begin
                    r_prod  <= (66'(r_err) - (r_label ? 66'sd65536 : 66'sd0))
                               * 66'(signed'(buf_rdata));
                    r_state <= S_GRD_WR;
                end
                S_GRD_WR: begin
                    r_g[r_j[AW-1:0]] <= lrt_pkg::sat48(66'(r_g[r_j[AW-1:0]])
                                                       + (r_prod >>> 12));
                    r_j     <= r_j + 1'b1;
                    r_state <= S_GRD_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/logistic_regression_trainer_top.sv]
// ----------------------------------------------------------------------------
// logistic_regression_trainer_top
// logistic regression trainer with cubic sigmoid, Q16.16 fixed point
//
// channel  dir  payload
// s_in     in   {op[1:0], feature[15:0], label, last_feature}
// m_out    out  {predicted_label, score[31:0]}
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// each request is run to its end by the back end sequencer, which reads the
// next one only after its registered pop; a train close also walks the
// sigmoid and gradient states, and an update op walks every weight
// synchronous active low reset clears weights, gradients and counters
// a two entry request queue lets intake run while the back end stalls
// ----------------------------------------------------------------------------
module logistic_regression_trainer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrt_stream_if.sink   s_in,
    lrt_stream_if.source m_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic [15:0]        r_lr;
    logic signed [31:0] r_c0, r_c1, r_c3, r_thr;
    logic               q_valid, q_pop;
    lrt_pkg::t_req      q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= 16'd6554;
            r_c0  <= 32'sd32768;
            r_c1  <= 32'sd9838;
            r_c3  <= -32'sd104;
            r_thr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lrt_pkg::REG_LR:  r_lr  <= i_cfg_data[15:0];
                lrt_pkg::REG_C0:  r_c0  <= i_cfg_data;
                lrt_pkg::REG_C1:  r_c1  <= i_cfg_data;
                lrt_pkg::REG_C3:  r_c3  <= i_cfg_data;
                lrt_pkg::REG_THR: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lrt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (s_in),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    lrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .i_lr      (r_lr),
        .i_c0      (r_c0),
        .i_c1      (r_c1),
        .i_c3      (r_c3),
        .i_thr     (r_thr),
        .m_out     (m_out)
    );
endmodule
